### design/hpqe_pkg.sv
// ----------------------------------------------------------------------------
// hpqe_pkg
// Types, constants and the arctangent table of the head pose converter.
// ----------------------------------------------------------------------------
package hpqe_pkg;

    localparam int CFG_W       = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int SCALE_W     = 8;
    localparam int AB_W        = 38;
    localparam int ANG_W       = 28;
    localparam int SQ_STAGES   = 31;
    localparam int CORDIC_ITER = 24;
    localparam int CORDIC_LAT  = CORDIC_ITER + 1;
    localparam int PROD_W      = ANG_W + SCALE_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_HOFF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOFF  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd2;

    localparam logic signed [CFG_W-1:0]   HOFF_RST  = 24'sd3276800;
    localparam logic signed [CFG_W-1:0]   VOFF_RST  = 24'sd1966080;
    localparam logic        [SCALE_W-1:0] SCALE_RST = 8'd45;

    localparam logic signed [ANG_W-1:0] HALF_PI = 28'sd26353589;

    typedef struct packed {
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_roll;
        logic signed [31:0] out_pitch;
        logic signed [31:0] out_yaw;
    } out_item_t;

    // atan(2^-i) in units of 2^-24 rad
    function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
        logic signed [ANG_W-1:0] e;
        case (i)
            0:       e = 28'sd13176795;
            1:       e = 28'sd7778716;
            2:       e = 28'sd4110060;
            3:       e = 28'sd2086331;
            4:       e = 28'sd1047214;
            5:       e = 28'sd524117;
            6:       e = 28'sd262123;
            7:       e = 28'sd131069;
            default: e = 28'sd1 <<< (24 - i);
        endcase
        return e;
    endfunction

endpackage

### design/head_pose_quat_to_euler_top.sv
// ----------------------------------------------------------------------------
// head_pose_quat_to_euler_top
// Head pose converter: translation offsets and quaternion to Euler angles.
// ----------------------------------------------------------------------------
// A pose is taken whenever start is high; busy is always low. Each pose gives
// one result, marked by done; a new pose may enter every cycle. The result
// passes through the 31-stage square root of the yaw path followed by the
// 25-stage atan2 pipeline. The receiver cannot stall and must take each result
// in its done cycle. Configuration writes take effect at once and should be
// made while no transaction is in flight.
module head_pose_quat_to_euler_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  hpqe_pkg::in_item_t                  in_item,
    output logic                                done,
    output hpqe_pkg::out_item_t                 out_item,
    input  logic                                cfg_we,
    input  logic [hpqe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hpqe_pkg::CFG_W-1:0]          cfg_data
);
    import hpqe_pkg::*;

    localparam int LAT       = 4 + SQ_STAGES + CORDIC_LAT + 2;
    localparam int TR_DEPTH  = LAT - 3;
    localparam int AB_DEPTH  = SQ_STAGES + 2;

    logic signed [CFG_W-1:0] hoff_reg;
    logic signed [CFG_W-1:0] voff_reg;
    logic [SCALE_W-1:0]      scale_reg;
    logic [LAT-1:0]          valid_reg;
    logic                    accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hoff_reg  <= HOFF_RST;
            voff_reg  <= VOFF_RST;
            scale_reg <= SCALE_RST;
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[LAT-2:0], accept};
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HOFF:  hoff_reg  <= cfg_data;
                    CFG_VOFF:  voff_reg  <= cfg_data;
                    CFG_SCALE: scale_reg <= cfg_data[SCALE_W-1:0];
                    default:   ;
                endcase
            end
        end
    end

    assign done = valid_reg[LAT-1];

    // stage 1: products and translations
    logic signed [31:0] p_yw_reg, p_xz_reg, p_yy_reg, p_zz_reg, p_xw_reg;
    logic signed [31:0] p_yz_reg, p_xx_reg, p_xy_reg, p_zw_reg;
    logic signed [31:0] tx_reg, ty_reg, tz_reg;
    logic signed [32:0] dx, dy;

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sd2147483647)
            r = 32'h7fffffff;
        else if (v < -33'sd2147483648)
            r = 32'h80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    always_comb
    begin
        dx = 33'(in_item.trans_x) - 33'(hoff_reg);
        dy = 33'(in_item.trans_y) - 33'(voff_reg);
    end

    always_ff @(posedge clk)
    begin
        p_yw_reg <= in_item.quat_y * in_item.quat_w;
        p_xz_reg <= in_item.quat_x * in_item.quat_z;
        p_yy_reg <= in_item.quat_y * in_item.quat_y;
        p_zz_reg <= in_item.quat_z * in_item.quat_z;
        p_xw_reg <= in_item.quat_x * in_item.quat_w;
        p_yz_reg <= in_item.quat_y * in_item.quat_z;
        p_xx_reg <= in_item.quat_x * in_item.quat_x;
        p_xy_reg <= in_item.quat_x * in_item.quat_y;
        p_zw_reg <= in_item.quat_z * in_item.quat_w;
        tx_reg   <= sat32(dx);
        ty_reg   <= sat32(dy);
        tz_reg   <= in_item.trans_z;
    end

    // stage 2: atan2 arguments and clamped asin argument
    logic signed [AB_W-1:0] ar_reg, br_reg, ap_reg, bp_reg;
    logic signed [31:0]     s_reg;
    logic signed [AB_W-1:0] s_raw;

    always_comb
    begin
        s_raw = (AB_W'(p_xy_reg) + AB_W'(p_zw_reg)) <<< 1;
    end

    always_ff @(posedge clk)
    begin
        ar_reg <= (AB_W'(p_yw_reg) - AB_W'(p_xz_reg)) <<< 1;
        br_reg <= (AB_W'(64'sd1073741824)) - ((AB_W'(p_yy_reg) + AB_W'(p_zz_reg)) <<< 1);
        ap_reg <= (AB_W'(p_xw_reg) - AB_W'(p_yz_reg)) <<< 1;
        bp_reg <= (AB_W'(64'sd1073741824)) - ((AB_W'(p_xx_reg) + AB_W'(p_zz_reg)) <<< 1);
        if (s_raw > AB_W'(64'sd1073741824))
            s_reg <= 32'sd1073741824;
        else if (s_raw < -AB_W'(64'sd1073741824))
            s_reg <= -32'sd1073741824;
        else
            s_reg <= s_raw[31:0];
    end

    // stages 3 and 4: radicand for the yaw cosine
    logic [63:0]        ssq_reg;
    logic [63:0]        rad_reg;
    logic signed [31:0] s3_reg, s4_reg;

    always_ff @(posedge clk)
    begin
        ssq_reg <= 64'(s_reg * s_reg);
        s3_reg  <= s_reg;
        rad_reg <= (64'd1 << 60) - ssq_reg;
        s4_reg  <= s3_reg;
    end

    logic [31:0]        c_root;
    logic signed [31:0] s_dly;

    hpqe_isqrt u_isqrt (
        .clk  (clk),
        .rad  (rad_reg),
        .root (c_root)
    );

    hpqe_delay #(.WIDTH(32), .DEPTH(SQ_STAGES)) u_s_dly (
        .clk  (clk),
        .din  (s4_reg),
        .dout (s_dly)
    );

    logic [4*AB_W-1:0] ab_dly;

    hpqe_delay #(.WIDTH(4*AB_W), .DEPTH(AB_DEPTH)) u_ab_dly (
        .clk  (clk),
        .din  ({ar_reg, br_reg, ap_reg, bp_reg}),
        .dout (ab_dly)
    );

    logic signed [ANG_W-1:0] ang_r, ang_p, ang_y;

    hpqe_cordic u_roll (
        .clk   (clk),
        .a     ($signed(ab_dly[4*AB_W-1:3*AB_W])),
        .b     ($signed(ab_dly[3*AB_W-1:2*AB_W])),
        .angle (ang_r)
    );

    hpqe_cordic u_pitch (
        .clk   (clk),
        .a     ($signed(ab_dly[2*AB_W-1:AB_W])),
        .b     ($signed(ab_dly[AB_W-1:0])),
        .angle (ang_p)
    );

    hpqe_cordic u_yaw (
        .clk   (clk),
        .a     (AB_W'(s_dly)),
        .b     ($signed(AB_W'(c_root))),
        .angle (ang_y)
    );

    logic [95:0] tr_dly;

    hpqe_delay #(.WIDTH(96), .DEPTH(TR_DEPTH)) u_tr_dly (
        .clk  (clk),
        .din  ({tx_reg, ty_reg, tz_reg}),
        .dout (tr_dly)
    );

    // scaling stage
    logic signed [PROD_W-1:0] pr_reg, pp_reg, py_reg;
    logic signed [SCALE_W:0]  scale_s;
    logic [95:0]              tr_reg;

    assign scale_s = $signed({1'b0, scale_reg});

    always_ff @(posedge clk)
    begin
        pr_reg <= scale_s * ang_r;
        pp_reg <= scale_s * ang_p;
        py_reg <= scale_s * ang_y;
        tr_reg <= tr_dly;
    end

    function automatic logic signed [31:0] to_q16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W:0] v;
        v = -(PROD_W+1)'(p) + (PROD_W+1)'(128);
        v = v >>> 8;
        return 32'(v);
    endfunction

    out_item_t res_next;

    always_comb
    begin
        res_next.out_x     = tr_reg[95:64];
        res_next.out_y     = tr_reg[63:32];
        res_next.out_z     = tr_reg[31:0];
        res_next.out_roll  = to_q16(pr_reg);
        res_next.out_pitch = to_q16(pp_reg);
        res_next.out_yaw   = to_q16(py_reg);
    end

    always_ff @(posedge clk)
    begin
        out_item <= res_next;
    end
endmodule

### design/hpqe_delay.sv
// ----------------------------------------------------------------------------
// hpqe_delay
// Fixed shift line that keeps side data in step with the pipeline.
// ----------------------------------------------------------------------------
module hpqe_delay #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);
    logic [WIDTH-1:0] tap_reg [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        tap_reg[0] <= din;
        for (int i = 1; i < DEPTH; i++)
        begin
            tap_reg[i] <= tap_reg[i-1];
        end
    end

    assign dout = tap_reg[DEPTH-1];
endmodule

### design/hpqe_isqrt.sv
// ----------------------------------------------------------------------------
// hpqe_isqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module hpqe_isqrt (
    input  logic        clk,
    input  logic [63:0] rad,
    output logic [31:0] root
);
    import hpqe_pkg::*;

    logic [63:0] v_reg [0:SQ_STAGES];
    logic [63:0] r_reg [0:SQ_STAGES];

    assign v_reg[0] = rad;
    assign r_reg[0] = '0;

    for (genvar j = 0; j < SQ_STAGES; j++)
    begin : g_stage
        localparam int K = SQ_STAGES - 1 - j;
        logic [63:0] bit_c;
        logic [63:0] trial;
        logic [63:0] v_next;
        logic [63:0] r_next;

        always_comb
        begin
            bit_c = 64'd1 << (2 * K);
            trial = r_reg[j] + bit_c;
            if (v_reg[j] >= trial)
            begin
                v_next = v_reg[j] - trial;
                r_next = (r_reg[j] >> 1) + bit_c;
            end
            else
            begin
                v_next = v_reg[j];
                r_next = r_reg[j] >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            v_reg[j+1] <= v_next;
            r_reg[j+1] <= r_next;
        end
    end

    assign root = r_reg[SQ_STAGES][31:0];
endmodule

### design/hpqe_cordic.sv
// ----------------------------------------------------------------------------
// hpqe_cordic
// Pipelined vectoring atan2 with quarter-turn pre-rotation.
// ----------------------------------------------------------------------------
module hpqe_cordic (
    input  logic                                clk,
    input  logic signed [hpqe_pkg::AB_W-1:0]    a,
    input  logic signed [hpqe_pkg::AB_W-1:0]    b,
    output logic signed [hpqe_pkg::ANG_W-1:0]   angle
);
    import hpqe_pkg::*;

    logic signed [AB_W-1:0]  x_reg [0:CORDIC_ITER];
    logic signed [AB_W-1:0]  y_reg [0:CORDIC_ITER];
    logic signed [ANG_W-1:0] z_reg [0:CORDIC_ITER];
    logic                    zero_reg [0:CORDIC_ITER];

    logic signed [AB_W-1:0]  x0_next;
    logic signed [AB_W-1:0]  y0_next;
    logic signed [ANG_W-1:0] z0_next;

    always_comb
    begin
        if (b < 0)
        begin
            if (a >= 0)
            begin
                x0_next = a;
                y0_next = -b;
                z0_next = HALF_PI;
            end
            else
            begin
                x0_next = -a;
                y0_next = b;
                z0_next = -HALF_PI;
            end
        end
        else
        begin
            x0_next = b;
            y0_next = a;
            z0_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= x0_next;
        y_reg[0]    <= y0_next;
        z_reg[0]    <= z0_next;
        zero_reg[0] <= (a == 0) && (b == 0);
    end

    for (genvar i = 0; i < CORDIC_ITER; i++)
    begin : g_iter
        logic signed [AB_W-1:0]  xs;
        logic signed [AB_W-1:0]  ys;
        logic signed [AB_W-1:0]  x_next;
        logic signed [AB_W-1:0]  y_next;
        logic signed [ANG_W-1:0] z_next;

        always_comb
        begin
            xs = x_reg[i] >>> i;
            ys = y_reg[i] >>> i;
            if (y_reg[i] >= 0)
            begin
                x_next = x_reg[i] + ys;
                y_next = y_reg[i] - xs;
                z_next = z_reg[i] + atan_entry(i);
            end
            else
            begin
                x_next = x_reg[i] - ys;
                y_next = y_reg[i] + xs;
                z_next = z_reg[i] - atan_entry(i);
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[i+1]    <= x_next;
            y_reg[i+1]    <= y_next;
            z_reg[i+1]    <= z_next;
            zero_reg[i+1] <= zero_reg[i];
        end
    end

    assign angle = zero_reg[CORDIC_ITER] ? '0 : z_reg[CORDIC_ITER];
endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the head pose converter: directed poses from a
// table, then random poses under several offset and scale settings, each result
// checked field by field with a bit-exact fixed-point predictor or given value.
// ----------------------------------------------------------------------------
module tb_top;
    import hpqe_pkg::*;

    localparam int LATENCY   = 62;
    localparam int N_RANDOM  = 950;
    localparam int MAX_CYCLE = 400000;

    typedef struct {
        in_item_t  pose;
        logic      known;
        out_item_t res;
    } pose_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_item_t    in_item;
    logic        done;
    out_item_t   out_item;
    logic        cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    logic signed [CFG_W-1:0] hoff_m;
    logic signed [CFG_W-1:0] voff_m;
    logic [SCALE_W-1:0]      scale_m;

    out_item_t   pending_q[$];
    int          n_fail;
    int          n_sent;
    int          n_checked;
    int          cycle;
    int          send_idle;

    head_pose_quat_to_euler_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_item   (in_item),
        .done      (done),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint atan_step(int i);
        longint t[8] = '{13176795, 7778716, 4110060, 2086331,
                         1047214, 524117, 262123, 131069};
        if (i < 8)
            return t[i];
        return 64'sd1 << (24 - i);
    endfunction

    function automatic longint vector_angle(longint a, longint b);
        longint x;
        longint y;
        longint z;
        longint nx;
        if (a == 0 && b == 0)
            return 0;
        if (b < 0)
        begin
            if (a >= 0)
            begin
                x = a; y = -b; z = 26353589;
            end
            else
            begin
                x = -a; y = b; z = -26353589;
            end
        end
        else
        begin
            x = b; y = a; z = 0;
        end
        for (int i = 0; i < 24; i++)
        begin
            if (y >= 0)
            begin
                nx = x + floor_shr(y, i);
                y  = y - floor_shr(x, i);
                z += atan_step(i);
            end
            else
            begin
                nx = x - floor_shr(y, i);
                y  = y + floor_shr(x, i);
                z -= atan_step(i);
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic logic signed [31:0] scaled_angle(longint ang);
        longint v;
        v = -longint'({1'b0, scale_m}) * ang;
        return 32'(clamp32(floor_shr(v + 128, 8)));
    endfunction

    function automatic out_item_t predict_pose(in_item_t p);
        out_item_t r;
        longint qx;
        longint qy;
        longint qz;
        longint qw;
        longint a;
        longint b;
        longint s;
        longint one;
        qx = p.quat_x; qy = p.quat_y; qz = p.quat_z; qw = p.quat_w;
        one = 64'sd1 << 30;
        r.out_x = 32'(clamp32(longint'(p.trans_x) - longint'(hoff_m)));
        r.out_y = 32'(clamp32(longint'(p.trans_y) - longint'(voff_m)));
        r.out_z = p.trans_z;
        a = 2 * (qy * qw - qx * qz);
        b = one - 2 * (qy * qy + qz * qz);
        r.out_roll = scaled_angle(vector_angle(a, b));
        a = 2 * (qx * qw - qy * qz);
        b = one - 2 * (qx * qx + qz * qz);
        r.out_pitch = scaled_angle(vector_angle(a, b));
        s = 2 * (qx * qy + qz * qw);
        if (s > one)
            s = one;
        if (s < -one)
            s = -one;
        r.out_yaw = scaled_angle(vector_angle(s, int_sqrt(one * one - s * s)));
        return r;
    endfunction

    function automatic in_item_t make_pose(logic signed [31:0] tx, logic signed [31:0] ty,
                                           logic signed [31:0] tz, logic signed [15:0] x,
                                           logic signed [15:0] y, logic signed [15:0] z,
                                           logic signed [15:0] w);
        in_item_t p;
        p = '{tx, ty, tz, x, y, z, w};
        return p;
    endfunction

    function automatic in_item_t random_pose();
        in_item_t p;
        int mode;
        real th;
        real ux;
        real uy;
        real uz;
        real uw;
        real n;
        p.trans_x = $urandom;
        p.trans_y = $urandom;
        p.trans_z = $urandom;
        mode = $urandom_range(0, 9);
        if (mode < 7)
        begin
            // near-unit quaternion with random orientation
            ux = real'(int'($urandom_range(0, 2000)) - 1000);
            uy = real'(int'($urandom_range(0, 2000)) - 1000);
            uz = real'(int'($urandom_range(0, 2000)) - 1000);
            uw = real'(int'($urandom_range(0, 2000)) - 1000);
            n = $sqrt(ux * ux + uy * uy + uz * uz + uw * uw);
            if (n < 1.0)
                n = 1.0;
            th = 32767.0 / n;
            p.quat_x = 16'(int'(ux * th));
            p.quat_y = 16'(int'(uy * th));
            p.quat_z = 16'(int'(uz * th));
            p.quat_w = 16'(int'(uw * th));
        end
        else if (mode < 9)
        begin
            p.quat_x = $urandom;
            p.quat_y = $urandom;
            p.quat_z = $urandom;
            p.quat_w = $urandom;
        end
        else
        begin
            p.quat_x = 16'(int'($urandom_range(0, 8)) - 4);
            p.quat_y = 16'(int'($urandom_range(0, 8)) - 4);
            p.quat_z = 16'(int'($urandom_range(0, 8)) - 4);
            p.quat_w = 16'(int'($urandom_range(0, 8)) - 4);
        end
        return p;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_HOFF)
            hoff_m = val;
        else if (idx == CFG_VOFF)
            voff_m = val;
        else if (idx == CFG_SCALE)
            scale_m = val[SCALE_W-1:0];
    endtask

    task automatic set_config(logic signed [CFG_W-1:0] h, logic signed [CFG_W-1:0] v,
                              logic [SCALE_W-1:0] s);
        write_reg(CFG_HOFF, h);
        write_reg(CFG_VOFF, v);
        write_reg(CFG_SCALE, {16'd0, s});
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (4)
            @(negedge clk);
    endtask

    // input changes at the falling edge, held until accepted
    task automatic send_pose(in_item_t p, logic known, out_item_t res);
        while (send_idle > 0 && $urandom_range(0, 99) < send_idle)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start   <= 1'b1;
        in_item <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_q.push_back(known ? res : predict_pose(p));
        n_sent++;
        @(negedge clk);
    endtask

    task automatic run_random(int n);
        out_item_t dummy;
        dummy = '0;
        for (int i = 0; i < n; i++)
            send_pose(random_pose(), 1'b0, dummy);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_q.size() == 0)
            begin
                $error("result with no transaction outstanding");
                n_fail++;
            end
            else
            begin
                out_item_t e;
                e = pending_q.pop_front();
                n_checked++;
                if (out_item.out_x !== e.out_x)
                begin
                    $error("out_x expected %0d got %0d", e.out_x, out_item.out_x);
                    n_fail++;
                end
                if (out_item.out_y !== e.out_y)
                begin
                    $error("out_y expected %0d got %0d", e.out_y, out_item.out_y);
                    n_fail++;
                end
                if (out_item.out_z !== e.out_z)
                begin
                    $error("out_z expected %0d got %0d", e.out_z, out_item.out_z);
                    n_fail++;
                end
                if (out_item.out_roll !== e.out_roll)
                begin
                    $error("out_roll expected %0d got %0d", e.out_roll, out_item.out_roll);
                    n_fail++;
                end
                if (out_item.out_pitch !== e.out_pitch)
                begin
                    $error("out_pitch expected %0d got %0d", e.out_pitch, out_item.out_pitch);
                    n_fail++;
                end
                if (out_item.out_yaw !== e.out_yaw)
                begin
                    $error("out_yaw expected %0d got %0d", e.out_yaw, out_item.out_yaw);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle++;
        if (cycle > MAX_CYCLE)
        begin
            $display("[head_pose_quat_to_euler_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        pose_row_t rows[$];
        out_item_t z;
        rst_n     = 1'b0;
        start     = 1'b0;
        in_item   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_HOFF;
        cfg_data  = '0;
        n_fail    = 0;
        n_sent    = 0;
        n_checked = 0;
        cycle     = 0;
        send_idle = 0;
        hoff_m    = HOFF_RST;
        voff_m    = VOFF_RST;
        scale_m   = SCALE_RST;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed poses after reset, starting with the identity pose; offsets removed
        z = '{-32'sd3276800, -32'sd1966080, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
        rows.push_back('{make_pose(0, 0, 0, 0, 0, 0, 16'sh7fff), 1'b0, z});
        rows.push_back('{make_pose(0, 0, 0, 0, 0, 0, 0), 1'b0, z});
        rows.push_back('{make_pose(32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                                   16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff), 1'b0, z});
        rows.push_back('{make_pose(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                                   16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000), 1'b0, z});
        rows.push_back('{make_pose(1, -1, 5, 16'sh7fff, 0, 0, 0), 1'b0, z});
        rows.push_back('{make_pose(2, -2, 6, 0, 16'sh7fff, 0, 0), 1'b0, z});
        rows.push_back('{make_pose(3, -3, 7, 0, 0, 16'sh7fff, 0), 1'b0, z});
        rows.push_back('{make_pose(4, -4, 8, 0, 0, 0, 16'sh8000), 1'b0, z});
        rows.push_back('{make_pose(0, 0, 0, 16'sh5a82, 16'sh5a82, 0, 0), 1'b0, z});
        rows.push_back('{make_pose(0, 0, 0, 16'sh5a82, 16'sha57e, 0, 0), 1'b0, z});
        rows.push_back('{make_pose(0, 0, 0, 0, 0, 16'sh5a82, 16'sh5a82), 1'b0, z});
        rows.push_back('{make_pose(0, 0, 0, 16'sh5a82, 0, 0, 16'sh5a82), 1'b0, z});
        rows.push_back('{make_pose(0, 0, 0, 0, 16'sh5a82, 0, 16'sha57e), 1'b0, z});
        rows.push_back('{make_pose(0, 0, 0, 16'sh8000, 16'sh8000, 0, 0), 1'b0, z});
        rows.push_back('{make_pose(0, 0, 0, 16'sh4000, 16'sh4000, 16'sh4000, 16'sh4000),
                         1'b0, z});
        foreach (rows[i])
            send_pose(rows[i].pose, rows[i].known, rows[i].res);
        drain_results();

        // large offsets, saturating subtraction, scale of 180
        set_config(-24'sd6553600, 24'sd6553600, 8'd180);
        rows.delete();
        rows.push_back('{make_pose(32'sh7fffffff, 32'sh80000000, 0, 0, 0, 0, 16'sh7fff), 1'b0,
                         z});
        rows.push_back('{make_pose(0, 0, 0, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff),
                         1'b0, z});
        rows.push_back('{make_pose(0, 0, 0, 0, 16'sh7fff, 0, 16'sh7fff), 1'b0, z});
        foreach (rows[i])
            send_pose(rows[i].pose, rows[i].known, rows[i].res);
        drain_results();

        // zero scale: all angle outputs zero
        set_config(24'sh7fffff, 24'sh800000, 8'd0);
        send_pose(make_pose(5, 5, 5, 16'sh1234, 16'sh7000, 16'sh8000, 16'sh0100), 1'b1,
                  '{32'sd5 - 32'sh7fffff, 32'sd5 + 32'sh800000, 32'sd5, 32'sd0, 32'sd0, 32'sd0});
        drain_results();

        set_config(24'sd1, -24'sd1, 8'd1);
        send_idle = 9;
        run_random(N_RANDOM / 3);
        drain_results();

        set_config(24'(int'($urandom_range(0, 13107200)) - 6553600),
                   24'(int'($urandom_range(0, 13107200)) - 6553600),
                   8'($urandom_range(1, 180)));
        send_idle = 70;
        run_random(N_RANDOM / 3);
        drain_results();

        set_config(HOFF_RST, VOFF_RST, 8'd255);
        send_idle = 0;
        run_random(N_RANDOM - 2 * (N_RANDOM / 3));

        start <= 1'b0;
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 8)
            @(negedge clk);
        $display("poses sent %0d, results checked %0d, mismatches %0d",
                 n_sent, n_checked, n_fail);
        $display("covered field extremes, zero and maximum scale, offset limits, three pacings");
        if (n_fail == 0 && pending_q.size() == 0)
            $display("[head_pose_quat_to_euler_top] OK");
        else
            $display("[head_pose_quat_to_euler_top] ERROR");
        $finish;
    end

endmodule
